// ===== design/bps_pkg.sv =====
// Shared types and constants for the bilinear RGB565 splat core.
`timescale 1ns / 1ps
`default_nettype none

package bps_pkg;

   // Beat control that travels down the pipeline with the data
   typedef struct packed {
      logic valid;   // stage holds a live beat
      logic last;    // fourth beat of the item
      logic dx;      // right-hand column of the cell pair
      logic dy;      // lower row of the cell pair
   } ctl_type;

   // Beat index within one item
   localparam logic [1:0] BEAT_FIRST = 2'd0;
   localparam logic [1:0] BEAT_LAST  = 2'd3;

   // RGB565 packing
   localparam int RB_BITS     = 5;    // red and blue full scale 31
   localparam int G_BITS      = 6;    // green full scale 63
   localparam int RED_SHIFT   = 11;
   localparam int GREEN_SHIFT = 5;
   localparam int COLOR_W     = 16;

endpackage

`default_nettype wire

// ===== design/bps_seq.sv =====
// Input holding stage: keeps one item and issues its four cell beats.
`timescale 1ns / 1ps
`default_nettype none

module bps_seq #(
   parameter int POS_W = 11,
   parameter int LVL_W = 9
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               adv,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic [POS_W-1:0]   req_x_pos,
   input  wire logic [POS_W-1:0]   req_y_pos,
   input  wire logic [LVL_W-1:0]   req_red_in,
   input  wire logic [LVL_W-1:0]   req_green_in,
   input  wire logic [LVL_W-1:0]   req_blue_in,
   output bps_pkg::ctl_type        beat_ctl,
   output logic [POS_W-1:0]        beat_x,
   output logic [POS_W-1:0]        beat_y,
   output logic [LVL_W-1:0]        beat_red,
   output logic [LVL_W-1:0]        beat_green,
   output logic [LVL_W-1:0]        beat_blue
);
   import bps_pkg::*;

   logic             busy_ff, busy_in;
   logic [1:0]       beat_ff, beat_in;
   logic [POS_W-1:0] x_ff, y_ff;
   logic [LVL_W-1:0] red_ff, green_ff, blue_ff;
   logic             take;
   logic             is_last;

   assign is_last   = (beat_ff == BEAT_LAST);
   // free when empty, or when the last beat leaves this cycle
   assign req_stall = busy_ff && !(is_last && adv);
   assign take      = req_valid && !req_stall;

   // beat counter and occupancy
   always_comb begin
      busy_in = busy_ff;
      beat_in = beat_ff;
      if (take) begin
         busy_in = 1'b1;
         beat_in = BEAT_FIRST;
      end else if (adv && busy_ff) begin
         if (is_last) begin
            busy_in = 1'b0;
         end else begin
            beat_in = beat_ff + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         beat_ff <= BEAT_FIRST;
      end else begin
         busy_ff <= busy_in;
         beat_ff <= beat_in;
      end
   end

   // item payload
   always_ff @(posedge clock) begin
      if (take) begin
         x_ff     <= req_x_pos;
         y_ff     <= req_y_pos;
         red_ff   <= req_red_in;
         green_ff <= req_green_in;
         blue_ff  <= req_blue_in;
      end
   end

   assign beat_ctl.valid = busy_ff;
   assign beat_ctl.last  = is_last;
   assign beat_ctl.dx    = beat_ff[0];
   assign beat_ctl.dy    = beat_ff[1];
   assign beat_x         = x_ff;
   assign beat_y         = y_ff;
   assign beat_red       = red_ff;
   assign beat_green     = green_ff;
   assign beat_blue      = blue_ff;

   // a new item always starts at the first beat
   a_take_starts: assert property (@(posedge clock) disable iff (reset)
      take |=> busy_ff && beat_ff == BEAT_FIRST)
      else $error("bps_seq: accepted item did not start at first beat");

   // a held beat waits while the pipeline is frozen
   a_hold: assert property (@(posedge clock) disable iff (reset)
      busy_ff && !adv |=> busy_ff && $stable(beat_ff))
      else $error("bps_seq: beat moved while pipeline frozen");

   // an item is never dropped before its last beat
   a_no_early_exit: assert property (@(posedge clock) disable iff (reset)
      busy_ff && !is_last |=> busy_ff)
      else $error("bps_seq: item left before its last beat");

endmodule

`default_nettype wire

// ===== design/bps_weight.sv =====
// Weight stages: per-beat fractions and cell address, then the wx*wy product.
`timescale 1ns / 1ps
`default_nettype none

module bps_weight #(
   parameter int FRAC_BITS = 8,
   parameter int GRID_BITS = 3
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             adv,
   input  wire bps_pkg::ctl_type                 beat_ctl,
   input  wire logic [GRID_BITS+FRAC_BITS-1:0]   beat_x,
   input  wire logic [GRID_BITS+FRAC_BITS-1:0]   beat_y,
   output bps_pkg::ctl_type                      w_ctl,
   output logic [2*FRAC_BITS:0]                  w_weight,
   output logic [GRID_BITS:0]                    w_column,
   output logic [GRID_BITS:0]                    w_row
);
   import bps_pkg::*;

   localparam int FW = FRAC_BITS + 1;   // 0.F fraction with room for 1.0
   localparam int CW = GRID_BITS + 1;   // cell coordinate, one past the grid
   localparam int WW = 2*FRAC_BITS + 1; // 1.2F weight
   localparam logic [FW-1:0] ONE_FRAC = FW'(1) << FRAC_BITS;

   logic [FRAC_BITS-1:0] fx, fy;
   logic [GRID_BITS-1:0] ix, iy;
   logic [FW-1:0]        wx_in, wy_in, wx_ff, wy_ff;
   logic [CW-1:0]        col1_in, row1_in, col1_ff, row1_ff;
   ctl_type              ctl1_ff, ctl2_ff;
   logic [2*FRAC_BITS:0] w2_in, w2_ff;
   logic [CW-1:0]        col2_ff, row2_ff;

   assign fx = beat_x[FRAC_BITS-1:0];
   assign fy = beat_y[FRAC_BITS-1:0];
   assign ix = beat_x[GRID_BITS+FRAC_BITS-1:FRAC_BITS];
   assign iy = beat_y[GRID_BITS+FRAC_BITS-1:FRAC_BITS];

   // stage 1: pick the fraction for this cell and form its address
   always_comb begin
      wx_in   = beat_ctl.dx ? FW'(fx) : ONE_FRAC - FW'(fx);
      wy_in   = beat_ctl.dy ? FW'(fy) : ONE_FRAC - FW'(fy);
      col1_in = CW'(ix) + CW'(beat_ctl.dx);
      row1_in = CW'(iy) + CW'(beat_ctl.dy);
   end

   // stage 2: bilinear weight, unsigned 1.2F
   assign w2_in = WW'(wx_ff) * WW'(wy_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl1_ff <= '0;
         ctl2_ff <= '0;
      end else if (adv) begin
         ctl1_ff <= beat_ctl;
         ctl2_ff <= ctl1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         wx_ff   <= wx_in;
         wy_ff   <= wy_in;
         col1_ff <= col1_in;
         row1_ff <= row1_in;
         w2_ff   <= w2_in;
         col2_ff <= col1_ff;
         row2_ff <= row1_ff;
      end
   end

   assign w_ctl    = ctl2_ff;
   assign w_weight = w2_ff;
   assign w_column = col2_ff;
   assign w_row    = row2_ff;

endmodule

`default_nettype wire

// ===== design/bps_scale.sv =====
// Channel scaling: weight times level, then times full scale, shifted and clamped.
`timescale 1ns / 1ps
`default_nettype none

module bps_scale #(
   parameter int FRAC_BITS = 8,
   parameter int OUT_BITS  = 5
) (
   input  wire logic                   clock,
   input  wire logic                   adv,
   input  wire logic [2*FRAC_BITS:0]   weight,
   input  wire logic [FRAC_BITS:0]     level,
   output logic [OUT_BITS-1:0]         chan
);
   import bps_pkg::*;

   localparam int WW = 2*FRAC_BITS + 1;
   localparam int LW = FRAC_BITS + 1;
   localparam int PW = WW + LW;            // weight * level
   localparam int SW = PW + OUT_BITS;      // times (2^OUT_BITS - 1)
   localparam int TW = SW - 3*FRAC_BITS;   // integer part after the shift
   localparam logic [TW-1:0] FULL_EXT = TW'((1 << OUT_BITS) - 1);

   logic [PW-1:0]       prod_in, prod_ff;
   logic [SW-1:0]       scaled;
   logic [TW-1:0]       whole;
   logic [OUT_BITS-1:0] chan_in, chan_ff;

   // stage 3: weight times level
   assign prod_in = PW'(weight) * PW'(level);

   // stage 4: times full scale as shift minus, truncate, clamp
   always_comb begin
      scaled  = (SW'(prod_ff) << OUT_BITS) - SW'(prod_ff);
      whole   = scaled[SW-1:3*FRAC_BITS];
      chan_in = (whole > FULL_EXT) ? FULL_EXT[OUT_BITS-1:0] : whole[OUT_BITS-1:0];
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         prod_ff <= prod_in;
         chan_ff <= chan_in;
      end
   end

   assign chan = chan_ff;

endmodule

`default_nettype wire

// ===== design/bilinear_pixel_splat_rgb565_core.sv =====
// Top level of the bilinear RGB565 splat core.
//
//  port group | dir | beat contents
//  -----------+-----+---------------------------------------------
//  req_*      | in  | x_pos, y_pos, red_in, green_in, blue_in
//  rsp_*      | out | column, row, color565, last
//
// Each item gives four write beats, one per cycle unless rsp is stalled, so
// a new item is taken only as the previous item's last beat leaves the hold
// stage; the single result beat per cycle on rsp sets that.
// Pipeline: hold/sequence, fractions, weight multiply, level multiply,
// full-scale clamp into the output register.
// Reset (synchronous) empties every stage; the data registers are not reset.
// rsp_stall freezes all stages together while a beat is held at the output;
// the input side keeps taking an item into its empty hold stage while the output waits.
`timescale 1ns / 1ps
`default_nettype none

module bilinear_pixel_splat_rgb565_core #(
   parameter int FRAC_BITS = 8,
   parameter int GRID_BITS = 3
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_valid,
   output logic                                  req_stall,
   input  wire logic [GRID_BITS+FRAC_BITS-1:0]   req_x_pos,
   input  wire logic [GRID_BITS+FRAC_BITS-1:0]   req_y_pos,
   input  wire logic [FRAC_BITS:0]               req_red_in,
   input  wire logic [FRAC_BITS:0]               req_green_in,
   input  wire logic [FRAC_BITS:0]               req_blue_in,
   output logic                                  rsp_valid,
   input  wire logic                             rsp_stall,
   output logic [GRID_BITS:0]                    rsp_column,
   output logic [GRID_BITS:0]                    rsp_row,
   output logic [bps_pkg::COLOR_W-1:0]           rsp_color565,
   output logic                                  rsp_last
);
   import bps_pkg::*;

   localparam int POS_W = GRID_BITS + FRAC_BITS;
   localparam int LVL_W = FRAC_BITS + 1;
   localparam int CW    = GRID_BITS + 1;

   logic             adv;
   ctl_type          beat_ctl, w_ctl, ctl3_ff, ctl4_ff;
   logic [POS_W-1:0] beat_x, beat_y;
   logic [LVL_W-1:0] beat_red, beat_green, beat_blue;
   logic [LVL_W-1:0] red1_ff, green1_ff, blue1_ff;
   logic [LVL_W-1:0] red2_ff, green2_ff, blue2_ff;
   logic [2*FRAC_BITS:0] w_weight;
   logic [CW-1:0]    w_column, w_row, col3_ff, row3_ff, col4_ff, row4_ff;
   logic [RB_BITS-1:0] red_q, blue_q;
   logic [G_BITS-1:0]  green_q;

   // whole pipeline moves unless a finished beat is held at the output
   assign adv = !(ctl4_ff.valid && rsp_stall);

   bps_seq #(.POS_W(POS_W), .LVL_W(LVL_W)) u_seq (
      .clock        (clock),
      .reset        (reset),
      .adv          (adv),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_x_pos    (req_x_pos),
      .req_y_pos    (req_y_pos),
      .req_red_in   (req_red_in),
      .req_green_in (req_green_in),
      .req_blue_in  (req_blue_in),
      .beat_ctl     (beat_ctl),
      .beat_x       (beat_x),
      .beat_y       (beat_y),
      .beat_red     (beat_red),
      .beat_green   (beat_green),
      .beat_blue    (beat_blue)
   );

   bps_weight #(.FRAC_BITS(FRAC_BITS), .GRID_BITS(GRID_BITS)) u_weight (
      .clock    (clock),
      .reset    (reset),
      .adv      (adv),
      .beat_ctl (beat_ctl),
      .beat_x   (beat_x),
      .beat_y   (beat_y),
      .w_ctl    (w_ctl),
      .w_weight (w_weight),
      .w_column (w_column),
      .w_row    (w_row)
   );

   // levels ride alongside the weight stages
   always_ff @(posedge clock) begin
      if (adv) begin
         red1_ff   <= beat_red;
         green1_ff <= beat_green;
         blue1_ff  <= beat_blue;
         red2_ff   <= red1_ff;
         green2_ff <= green1_ff;
         blue2_ff  <= blue1_ff;
         col3_ff   <= w_column;
         row3_ff   <= w_row;
         col4_ff   <= col3_ff;
         row4_ff   <= row3_ff;
      end
   end

   // control for the scaling stages and the output register
   always_ff @(posedge clock) begin
      if (reset) begin
         ctl3_ff <= '0;
         ctl4_ff <= '0;
      end else if (adv) begin
         ctl3_ff <= w_ctl;
         ctl4_ff <= ctl3_ff;
      end
   end

   bps_scale #(.FRAC_BITS(FRAC_BITS), .OUT_BITS(RB_BITS)) u_scale_red (
      .clock  (clock),
      .adv    (adv),
      .weight (w_weight),
      .level  (red2_ff),
      .chan   (red_q)
   );

   bps_scale #(.FRAC_BITS(FRAC_BITS), .OUT_BITS(G_BITS)) u_scale_green (
      .clock  (clock),
      .adv    (adv),
      .weight (w_weight),
      .level  (green2_ff),
      .chan   (green_q)
   );

   bps_scale #(.FRAC_BITS(FRAC_BITS), .OUT_BITS(RB_BITS)) u_scale_blue (
      .clock  (clock),
      .adv    (adv),
      .weight (w_weight),
      .level  (blue2_ff),
      .chan   (blue_q)
   );

   // RGB565 packing of the output register
   assign rsp_valid    = ctl4_ff.valid;
   assign rsp_last     = ctl4_ff.last;
   assign rsp_column   = col4_ff;
   assign rsp_row      = row4_ff;
   assign rsp_color565 = (COLOR_W'(red_q) << RED_SHIFT)
                       | (COLOR_W'(green_q) << GREEN_SHIFT)
                       | COLOR_W'(blue_q);

   // an accepted item keeps the input side busy for its remaining beats
   a_busy_after_take: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("core: input taken again right after an accept");

   // a held output beat freezes the stage behind it
   a_freeze: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(ctl3_ff) && $stable(col3_ff))
      else $error("core: pipeline moved under output stall");

   // the last marker reaches the output with its beat
   a_last_moves: assert property (@(posedge clock) disable iff (reset)
      ctl3_ff.valid && ctl3_ff.last && adv |=> rsp_valid && rsp_last)
      else $error("core: last beat lost between scale stages");

endmodule

`default_nettype wire
